>>> hw/rtl/tlwaq_pkg.sv
// ----------------------------------------------------------------------------
// tlwaq_pkg
// shared types, codes and the weighted schedule table for the admission queue
// ----------------------------------------------------------------------------
package tlwaq_pkg;

  // sizing
  localparam int QUEUE_SLOTS = 64;
  localparam int TAG_BITS    = 16;
  localparam int MAX_WORKERS = 16;

  localparam int SLOT_BITS   = $clog2(QUEUE_SLOTS);
  localparam int CNT_BITS    = SLOT_BITS + 1;
  localparam int ACT_BITS    = $clog2(MAX_WORKERS + 1);
  localparam int LANES       = 3;
  localparam int LANE_BITS   = 2;
  localparam int ADDR_BITS   = LANE_BITS + SLOT_BITS;
  localparam int MEM_DEPTH   = 1 << ADDR_BITS;
  localparam int WRR_SLOTS   = 7;

  // register file
  localparam int CFG_BITS    = 7;
  localparam int CFG_IDX_BITS = 3;
  localparam int WORKER_BITS = 5;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CAPACITY        = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIRECT_RESERVE  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NONDIRECT_LIMIT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OPTIONAL_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WORKER_LIMIT    = 3'd4;

  localparam logic [CFG_BITS-1:0]    RST_CAPACITY        = 7'd64;
  localparam logic [CFG_BITS-1:0]    RST_DIRECT_RESERVE  = 7'd16;
  localparam logic [CFG_BITS-1:0]    RST_NONDIRECT_LIMIT = 7'd48;
  localparam logic [CFG_BITS-1:0]    RST_OPTIONAL_LIMIT  = 7'd32;
  localparam logic [WORKER_BITS-1:0] RST_WORKER_LIMIT    = 5'd1;

  // commands
  localparam logic [2:0] FUNC_SUBMIT   = 3'd0;
  localparam logic [2:0] FUNC_DISPATCH = 3'd1;
  localparam logic [2:0] FUNC_COMPLETE = 3'd2;
  localparam logic [2:0] FUNC_START    = 3'd3;
  localparam logic [2:0] FUNC_STOP     = 3'd4;
  localparam logic [2:0] FUNC_SNAPSHOT = 3'd5;

  // lanes
  localparam logic [LANE_BITS-1:0] LANE_DIRECT   = 2'd0;
  localparam logic [LANE_BITS-1:0] LANE_EXPLICIT = 2'd1;
  localparam logic [LANE_BITS-1:0] LANE_OPTIONAL = 2'd2;

  // result status
  localparam logic [3:0] ST_ACCEPTED        = 4'd0;
  localparam logic [3:0] ST_FULL            = 4'd1;
  localparam logic [3:0] ST_NOT_ACCEPTING   = 4'd2;
  localparam logic [3:0] ST_DISPATCHED      = 4'd3;
  localparam logic [3:0] ST_NOTHING_READY   = 4'd4;
  localparam logic [3:0] ST_COMPLETED       = 4'd5;
  localparam logic [3:0] ST_NOTHING_ACTIVE  = 4'd6;
  localparam logic [3:0] ST_STARTED         = 4'd7;
  localparam logic [3:0] ST_ALREADY_STARTED = 4'd8;
  localparam logic [3:0] ST_CANCELLED       = 4'd9;
  localparam logic [3:0] ST_STOPPED         = 4'd10;
  localparam logic [3:0] ST_SNAPSHOT        = 4'd11;

  typedef logic [SLOT_BITS-1:0] slot_t;
  typedef logic [CNT_BITS-1:0]  count_t;

  typedef struct packed {
    logic                cancel;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  // 4 direct, 2 explicit, 1 optional
  function automatic logic [LANE_BITS-1:0] wrr_lane(input logic [2:0] pos);
    logic [LANE_BITS-1:0] l;
    unique case (pos)
      3'd0, 3'd1, 3'd2, 3'd3: l = LANE_DIRECT;
      3'd4, 3'd5:             l = LANE_EXPLICIT;
      default:                l = LANE_OPTIONAL;
    endcase
    return l;
  endfunction

  // (head + offset) mod QUEUE_SLOTS, offset below QUEUE_SLOTS
  function automatic slot_t slot_add(input slot_t head, input slot_t offs);
    logic [SLOT_BITS:0] sum;
    sum = {1'b0, head} + {1'b0, offs};
    if (32'(sum) >= QUEUE_SLOTS) begin
      sum = sum - CNT_BITS'(QUEUE_SLOTS);
    end
    return sum[SLOT_BITS-1:0];
  endfunction

endpackage

>>> hw/rtl/three_lane_weighted_admission_queue.sv
// ----------------------------------------------------------------------------
// three_lane_weighted_admission_queue
// three fifo lanes of task tags in one shared store, weighted dispatch, flush
// ----------------------------------------------------------------------------
// results: submit, complete, start, snapshot and a refused dispatch load the
//   output register the cycle after the item is taken; a dispatch reads the
//   store first; new items are taken only while idle with the output free;
//   stop reads the store once per flushed entry and waits on output stalls
// reset: synchronous, clears lanes, schedule, counters and intake; registers
//   return to 64/16/48/32/1; store contents stay undefined and are never read
// ----------------------------------------------------------------------------
module three_lane_weighted_admission_queue (
  input  logic                             clk,
  input  logic                             rst,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [tlwaq_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [tlwaq_pkg::CFG_BITS-1:0]   cfg_data,
  // command items
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       func,
  input  logic [1:0]                       lane,
  input  logic [tlwaq_pkg::TAG_BITS-1:0]   task_tag,
  input  logic                             has_cancel,
  // result items
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [3:0]                       status,
  output logic [1:0]                       lane_out,
  output logic [tlwaq_pkg::TAG_BITS-1:0]   tag_out,
  output logic                             last,
  output logic [6:0]                       queued_total,
  output logic [4:0]                       active_total,
  output logic                             accepting_flag
);

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DISP    = 3'd1;  // dispatch read in flight
  localparam logic [2:0] S_FL_ADDR = 3'd2;  // flush: issue next entry read
  localparam logic [2:0] S_FL_DATA = 3'd3;  // flush: look at entry
  localparam logic [2:0] S_FL_END  = 3'd4;  // flush: final result

  localparam int LN = tlwaq_pkg::LANES;
  localparam int CB = tlwaq_pkg::CNT_BITS;
  localparam int AB = tlwaq_pkg::ACT_BITS;
  localparam int LB = tlwaq_pkg::LANE_BITS;

  // configuration registers
  logic [tlwaq_pkg::CFG_BITS-1:0]    capacity;
  logic [tlwaq_pkg::CFG_BITS-1:0]    direct_reserve;
  logic [tlwaq_pkg::CFG_BITS-1:0]    nondirect_limit;
  logic [tlwaq_pkg::CFG_BITS-1:0]    optional_limit;
  logic [tlwaq_pkg::WORKER_BITS-1:0] worker_limit;

  // lane bookkeeping, one head and count per lane
  tlwaq_pkg::slot_t  head       [LN];
  tlwaq_pkg::slot_t  head_next  [LN];
  tlwaq_pkg::count_t count      [LN];
  tlwaq_pkg::count_t count_next [LN];
  logic [2:0]        sched_pos, sched_pos_next;
  logic [AB-1:0]     active_tasks, active_tasks_next;
  logic              accepting, accepting_next;
  logic              started, started_next;
  logic [2:0]        state, state_next;

  // dispatch and flush context
  logic [LB-1:0]     disp_lane, disp_lane_next;
  tlwaq_pkg::slot_t  fl_head       [LN];
  tlwaq_pkg::slot_t  fl_head_next  [LN];
  tlwaq_pkg::count_t fl_count      [LN];
  tlwaq_pkg::count_t fl_count_next [LN];
  logic [LB-1:0]     fl_lane, fl_lane_next;
  tlwaq_pkg::count_t fl_idx, fl_idx_next;
  // one cancelled entry held back until we know whether it is the last one
  logic              pend_valid, pend_valid_next;
  logic [LB-1:0]     pend_lane, pend_lane_next;
  logic [tlwaq_pkg::TAG_BITS-1:0] pend_tag, pend_tag_next;

  // output register
  logic              out_load;
  logic [3:0]        o_status;
  logic [LB-1:0]     o_lane;
  logic [tlwaq_pkg::TAG_BITS-1:0] o_tag;
  logic              o_last;

  // shared lane store: address is {lane, slot}
  tlwaq_pkg::entry_t                 store [tlwaq_pkg::MEM_DEPTH];
  tlwaq_pkg::entry_t                 rd_data;
  logic                              mem_re, mem_we;
  logic [tlwaq_pkg::ADDR_BITS-1:0]   mem_raddr, mem_waddr;
  tlwaq_pkg::entry_t                 mem_wdata;

  logic slot_free, accept;

  // submit checks
  logic [LB-1:0]                  sub_l;
  tlwaq_pkg::slot_t               sub_head;
  tlwaq_pkg::count_t              sub_count;
  logic [tlwaq_pkg::CFG_BITS-1:0] cap_eff, nd_cap;
  logic [7:0]                     qtotal, nondirect;
  logic [3:0]                     sub_status;

  // dispatch checks and weighted pick
  logic [tlwaq_pkg::WORKER_BITS-1:0] workers_eff;
  logic [LN-1:0]     lane_busy;
  logic              disp_refuse;
  logic [LB-1:0]     wrr_pick;
  logic [2:0]        wrr_pos_after;
  tlwaq_pkg::slot_t  pick_head;

  // flush lane selection
  tlwaq_pkg::slot_t  fl_head_sel;
  tlwaq_pkg::count_t fl_count_sel;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  // totals track the live state, which only moves on the next item accept
  assign queued_total   = 7'(qtotal);
  assign active_total   = 5'(active_tasks);
  assign accepting_flag = accepting;

  // lane selection and admission limits
  always_comb begin
    sub_l     = (lane >= LB'(tlwaq_pkg::LANE_OPTIONAL)) ? tlwaq_pkg::LANE_OPTIONAL : lane;
    sub_head  = '0;
    sub_count = '0;
    pick_head = '0;
    fl_head_sel  = '0;
    fl_count_sel = '0;
    for (int k = 0; k < LN; k++) begin
      lane_busy[k] = (count[k] != '0);
      if (LB'(k) == sub_l) begin
        sub_head  = head[k];
        sub_count = count[k];
      end
      if (LB'(k) == wrr_pick) begin
        pick_head = head[k];
      end
      if (LB'(k) == fl_lane) begin
        fl_head_sel  = fl_head[k];
        fl_count_sel = fl_count[k];
      end
    end

    qtotal    = 8'(count[0]) + 8'(count[1]) + 8'(count[2]);
    nondirect = 8'(count[1]) + 8'(count[2]);
    // capacity above the store size acts as the store size
    cap_eff   = (32'(capacity) > tlwaq_pkg::QUEUE_SLOTS) ?
                tlwaq_pkg::CFG_BITS'(tlwaq_pkg::QUEUE_SLOTS) : capacity;
    // reserve not below capacity is ignored
    nd_cap    = (cap_eff > direct_reserve) ? (cap_eff - direct_reserve) : cap_eff;

    priority if (!accepting) begin
      sub_status = tlwaq_pkg::ST_NOT_ACCEPTING;
    end else if (qtotal >= 8'(cap_eff)) begin
      sub_status = tlwaq_pkg::ST_FULL;
    end else if (sub_l != tlwaq_pkg::LANE_DIRECT && nondirect >= 8'(nd_cap)) begin
      sub_status = tlwaq_pkg::ST_FULL;
    end else if (sub_l != tlwaq_pkg::LANE_DIRECT && nondirect >= 8'(nondirect_limit)) begin
      sub_status = tlwaq_pkg::ST_FULL;
    end else if (sub_l == tlwaq_pkg::LANE_OPTIONAL &&
                 8'(count[2]) >= 8'(optional_limit)) begin
      sub_status = tlwaq_pkg::ST_FULL;
    end else begin
      sub_status = tlwaq_pkg::ST_ACCEPTED;
    end

    // worker count above the maximum acts as the maximum, zero blocks dispatch
    workers_eff = (32'(worker_limit) > tlwaq_pkg::MAX_WORKERS) ?
                  tlwaq_pkg::WORKER_BITS'(tlwaq_pkg::MAX_WORKERS) : worker_limit;
    disp_refuse = (qtotal == '0) || (32'(active_tasks) >= 32'(workers_eff));
  end

  // weighted round robin: walk the 7-slot table from the current position,
  // skipping empty lanes; some lane is non-empty whenever the pick is used
  always_comb begin
    logic [2:0] p;
    logic       found;
    p             = sched_pos;
    found         = 1'b0;
    wrr_pick      = tlwaq_pkg::LANE_DIRECT;
    wrr_pos_after = sched_pos;
    for (int i = 0; i < tlwaq_pkg::WRR_SLOTS; i++) begin
      if (!found && lane_busy[tlwaq_pkg::wrr_lane(p)]) begin
        found         = 1'b1;
        wrr_pick      = tlwaq_pkg::wrr_lane(p);
        wrr_pos_after = (p == 3'(tlwaq_pkg::WRR_SLOTS - 1)) ? 3'd0 : p + 3'd1;
      end
      p = (p == 3'(tlwaq_pkg::WRR_SLOTS - 1)) ? 3'd0 : p + 3'd1;
    end
  end

  // command sequencer
  always_comb begin
    head_next         = head;
    count_next        = count;
    sched_pos_next    = sched_pos;
    active_tasks_next = active_tasks;
    accepting_next    = accepting;
    started_next      = started;
    state_next        = state;
    disp_lane_next    = disp_lane;
    fl_head_next      = fl_head;
    fl_count_next     = fl_count;
    fl_lane_next      = fl_lane;
    fl_idx_next       = fl_idx;
    pend_valid_next   = pend_valid;
    pend_lane_next    = pend_lane;
    pend_tag_next     = pend_tag;

    out_load  = 1'b0;
    o_status  = tlwaq_pkg::ST_SNAPSHOT;
    o_lane    = '0;
    o_tag     = '0;
    o_last    = 1'b1;

    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = {sub_l, tlwaq_pkg::slot_add(sub_head, sub_count[CB-2:0])};
    mem_wdata = '{cancel: has_cancel, tag: task_tag};

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func)
            tlwaq_pkg::FUNC_SUBMIT: begin
              out_load = 1'b1;
              o_status = sub_status;
              if (sub_status == tlwaq_pkg::ST_ACCEPTED) begin
                mem_we = 1'b1;
                for (int k = 0; k < LN; k++) begin
                  if (LB'(k) == sub_l) begin
                    count_next[k] = count[k] + CB'(1);
                  end
                end
              end
            end
            tlwaq_pkg::FUNC_DISPATCH: begin
              if (disp_refuse) begin
                out_load = 1'b1;
                o_status = tlwaq_pkg::ST_NOTHING_READY;
              end else begin
                // read the head entry, the result goes out once it returns
                mem_re            = 1'b1;
                mem_raddr         = {wrr_pick, pick_head};
                sched_pos_next    = wrr_pos_after;
                active_tasks_next = active_tasks + AB'(1);
                disp_lane_next    = wrr_pick;
                for (int k = 0; k < LN; k++) begin
                  if (LB'(k) == wrr_pick) begin
                    head_next[k]  = tlwaq_pkg::slot_add(head[k], tlwaq_pkg::SLOT_BITS'(1));
                    count_next[k] = count[k] - CB'(1);
                  end
                end
                state_next = S_DISP;
              end
            end
            tlwaq_pkg::FUNC_COMPLETE: begin
              out_load = 1'b1;
              if (active_tasks == '0) begin
                o_status = tlwaq_pkg::ST_NOTHING_ACTIVE;
              end else begin
                o_status          = tlwaq_pkg::ST_COMPLETED;
                active_tasks_next = active_tasks - AB'(1);
              end
            end
            tlwaq_pkg::FUNC_START: begin
              out_load = 1'b1;
              if (started) begin
                o_status = tlwaq_pkg::ST_ALREADY_STARTED;
              end else begin
                o_status       = tlwaq_pkg::ST_STARTED;
                started_next   = 1'b1;
                accepting_next = 1'b1;
              end
            end
            tlwaq_pkg::FUNC_STOP: begin
              // snapshot the lanes, empty them at once, then scan the snapshot
              accepting_next  = 1'b0;
              fl_head_next    = head;
              fl_count_next   = count;
              for (int k = 0; k < LN; k++) begin
                head_next[k]  = '0;
                count_next[k] = '0;
              end
              fl_lane_next    = tlwaq_pkg::LANE_DIRECT;
              fl_idx_next     = '0;
              pend_valid_next = 1'b0;
              state_next      = S_FL_ADDR;
            end
            tlwaq_pkg::FUNC_SNAPSHOT: begin
              out_load = 1'b1;
              o_status = tlwaq_pkg::ST_SNAPSHOT;
            end
            default: begin
              // unused codes: taken, no result
            end
          endcase
        end
      end

      S_DISP: begin
        if (slot_free) begin
          out_load   = 1'b1;
          o_status   = tlwaq_pkg::ST_DISPATCHED;
          o_lane     = disp_lane;
          o_tag      = rd_data.tag;
          state_next = S_IDLE;
        end
      end

      S_FL_ADDR: begin
        if (fl_idx < fl_count_sel) begin
          mem_re     = 1'b1;
          mem_raddr  = {fl_lane, tlwaq_pkg::slot_add(fl_head_sel, fl_idx[CB-2:0])};
          state_next = S_FL_DATA;
        end else if (fl_lane == tlwaq_pkg::LANE_OPTIONAL) begin
          state_next = S_FL_END;
        end else begin
          fl_lane_next = fl_lane + LB'(1);
          fl_idx_next  = '0;
        end
      end

      S_FL_DATA: begin
        if (!rd_data.cancel) begin
          fl_idx_next = fl_idx + CB'(1);
          state_next  = S_FL_ADDR;
        end else if (!pend_valid || slot_free) begin
          // a newer cancel exists, so the held one is not the last
          if (pend_valid) begin
            out_load = 1'b1;
            o_status = tlwaq_pkg::ST_CANCELLED;
            o_lane   = pend_lane;
            o_tag    = pend_tag;
            o_last   = 1'b0;
          end
          pend_valid_next = 1'b1;
          pend_lane_next  = fl_lane;
          pend_tag_next   = rd_data.tag;
          fl_idx_next     = fl_idx + CB'(1);
          state_next      = S_FL_ADDR;
        end
      end

      S_FL_END: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (pend_valid) begin
            o_status = tlwaq_pkg::ST_CANCELLED;
            o_lane   = pend_lane;
            o_tag    = pend_tag;
          end else begin
            o_status = tlwaq_pkg::ST_STOPPED;
          end
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // lane store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= store[mem_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity        <= tlwaq_pkg::RST_CAPACITY;
      direct_reserve  <= tlwaq_pkg::RST_DIRECT_RESERVE;
      nondirect_limit <= tlwaq_pkg::RST_NONDIRECT_LIMIT;
      optional_limit  <= tlwaq_pkg::RST_OPTIONAL_LIMIT;
      worker_limit    <= tlwaq_pkg::RST_WORKER_LIMIT;
      for (int k = 0; k < LN; k++) begin
        head[k]     <= '0;
        count[k]    <= '0;
        fl_head[k]  <= '0;
        fl_count[k] <= '0;
      end
      sched_pos    <= '0;
      active_tasks <= '0;
      accepting    <= 1'b0;
      started      <= 1'b0;
      state        <= S_IDLE;
      fl_lane      <= '0;
      fl_idx       <= '0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tlwaq_pkg::CFG_CAPACITY:        capacity        <= cfg_data;
          tlwaq_pkg::CFG_DIRECT_RESERVE:  direct_reserve  <= cfg_data;
          tlwaq_pkg::CFG_NONDIRECT_LIMIT: nondirect_limit <= cfg_data;
          tlwaq_pkg::CFG_OPTIONAL_LIMIT:  optional_limit  <= cfg_data;
          tlwaq_pkg::CFG_WORKER_LIMIT:
            worker_limit <= cfg_data[tlwaq_pkg::WORKER_BITS-1:0];
          default: begin
          end
        endcase
      end
      head         <= head_next;
      count        <= count_next;
      fl_head      <= fl_head_next;
      fl_count     <= fl_count_next;
      sched_pos    <= sched_pos_next;
      active_tasks <= active_tasks_next;
      accepting    <= accepting_next;
      started      <= started_next;
      state        <= state_next;
      fl_lane      <= fl_lane_next;
      fl_idx       <= fl_idx_next;
      pend_valid   <= pend_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    disp_lane <= disp_lane_next;
    pend_lane <= pend_lane_next;
    pend_tag  <= pend_tag_next;
    if (out_load) begin
      status   <= o_status;
      lane_out <= o_lane;
      tag_out  <= o_tag;
      last     <= o_last;
    end
  end

endmodule

>>> tb/three_lane_weighted_admission_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_lane_weighted_admission_queue_test
// self-checking bench: commands go in through a valid/ready driver, every
// result is checked field by field against a cycle-free model of the lanes,
// the admission limits, the weighted dispatch schedule and the stop flush
// ----------------------------------------------------------------------------
module three_lane_weighted_admission_queue_test;
  import tlwaq_pkg::*;

  // func codes the block has to ignore, and the lane code that aliases optional
  localparam logic [2:0]           FUNC_SPARE_A = 3'd6;
  localparam logic [2:0]           FUNC_SPARE_B = 3'd7;
  localparam logic [LANE_BITS-1:0] LANE_SPARE   = 2'd3;

  localparam int MAX_GAP       = 7;
  // ignored items give no result, so let the block settle before a reg write
  localparam int SETTLE_CYCLES = 12;

  // room for every command and every result of the whole run
  localparam int BACKLOG_DEPTH = 2048;
  localparam int AWAIT_DEPTH   = 4096;

  typedef struct packed {
    logic [2:0]          func;
    logic [1:0]          lane;
    logic [TAG_BITS-1:0] tag;
    logic                cancel;
  } command_t;

  // field order matches the output port order, so a concat of the ports fits
  typedef struct packed {
    logic [3:0]          status;
    logic [1:0]          lane;
    logic [TAG_BITS-1:0] tag;
    logic                last;
    logic [6:0]          queued;
    logic [4:0]          active;
    logic                accepting;
  } result_t;

  // dut ports
  logic                    clk;
  logic                    rst        = 1'b1;
  logic                    cfg_we     = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index  = '0;
  logic [CFG_BITS-1:0]     cfg_data   = '0;
  logic                    in_valid   = 1'b0;
  logic                    in_ready;
  logic [2:0]              func       = FUNC_SNAPSHOT;
  logic [1:0]              lane       = LANE_DIRECT;
  logic [TAG_BITS-1:0]     task_tag   = '0;
  logic                    has_cancel = 1'b0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic [3:0]              status;
  logic [1:0]              lane_out;
  logic [TAG_BITS-1:0]     tag_out;
  logic                    last;
  logic [6:0]              queued_total;
  logic [4:0]              active_total;
  logic                    accepting_flag;

  // bench bookkeeping
  command_t command_backlog [BACKLOG_DEPTH];
  int       backlog_wr      = 0;
  int       backlog_rd      = 0;
  result_t  awaited_results [AWAIT_DEPTH];
  int       await_wr        = 0;
  int       await_rd        = 0;
  command_t next_cmd;
  int       commands_issued = 0;
  int       commands_taken  = 0;
  int       mismatch_count  = 0;
  int       send_hold       = 0;
  int       recv_hold       = 0;
  bit       no_gaps         = 1'b0;
  logic     cmd_taken       = 1'b0;
  logic     result_taken    = 1'b0;

  // model state: registers, lanes, schedule, counters
  logic [CFG_BITS-1:0]    capacity_reg;
  logic [CFG_BITS-1:0]    reserve_reg;
  logic [CFG_BITS-1:0]    nondirect_reg;
  logic [CFG_BITS-1:0]    optional_reg;
  logic [WORKER_BITS-1:0] workers_reg;
  entry_t                 lane_store [LANES][QUEUE_SLOTS];
  int                     lane_head [LANES];
  int                     lane_fill [LANES];
  int                     weighted_pos;
  int                     busy_tasks;
  bit                     intake_open;
  bit                     ever_started;

  three_lane_weighted_admission_queue DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .lane           (lane),
    .task_tag       (task_tag),
    .has_cancel     (has_cancel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .lane_out       (lane_out),
    .tag_out        (tag_out),
    .last           (last),
    .queued_total   (queued_total),
    .active_total   (active_total),
    .accepting_flag (accepting_flag)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ------------------------------------------------------------------------
  // queue model
  // ------------------------------------------------------------------------

  task automatic clear_queue_model();
    int l;
    capacity_reg  = RST_CAPACITY;
    reserve_reg   = RST_DIRECT_RESERVE;
    nondirect_reg = RST_NONDIRECT_LIMIT;
    optional_reg  = RST_OPTIONAL_LIMIT;
    workers_reg   = RST_WORKER_LIMIT;
    for (l = 0; l < LANES; l++) begin
      lane_head[l] = 0;
      lane_fill[l] = 0;
    end
    weighted_pos = 0;
    busy_tasks   = 0;
    intake_open  = 1'b0;
    ever_started = 1'b0;
  endtask

  function automatic int lanes_total();
    return lane_fill[LANE_DIRECT] + lane_fill[LANE_EXPLICIT] + lane_fill[LANE_OPTIONAL];
  endfunction

  // seven schedule slots: four direct, two explicit, one optional
  function automatic int slot_lane(int pos);
    if (pos < 4) return int'(LANE_DIRECT);
    if (pos < 6) return int'(LANE_EXPLICIT);
    return int'(LANE_OPTIONAL);
  endfunction

  // totals in every result reflect the state after the whole command
  function automatic result_t make_result(logic [3:0] st, logic [1:0] ln,
                                          logic [TAG_BITS-1:0] tg, logic lst);
    result_t r;
    r.status    = st;
    r.lane      = ln;
    r.tag       = tg;
    r.last      = lst;
    r.queued    = 7'(lanes_total());
    r.active    = 5'(busy_tasks);
    r.accepting = intake_open;
    return r;
  endfunction

  // appends one result to the list of awaited results
  task automatic add_expected(input result_t r);
    awaited_results[await_wr] = r;
    await_wr++;
  endtask

  // works out the results of one accepted command and queues them
  task automatic predict_queue_step(input command_t c);
    int      eff_cap, nd_bound, nondirect, workers, ln, pick, pos, i, l, j;
    int      old_head [LANES];
    int      old_fill [LANES];
    logic [3:0] verdict;
    entry_t  e;
    result_t held;
    bit      have_held;
    case (c.func)
      FUNC_SUBMIT: begin
        // capacity above the store size acts as the store size
        eff_cap   = (int'(capacity_reg) > QUEUE_SLOTS) ? QUEUE_SLOTS : int'(capacity_reg);
        nondirect = lane_fill[LANE_EXPLICIT] + lane_fill[LANE_OPTIONAL];
        // a reserve that is not below capacity is ignored
        nd_bound  = (eff_cap > int'(reserve_reg)) ? eff_cap - int'(reserve_reg) : eff_cap;
        // lane code three lands in the optional lane
        ln        = (c.lane >= LANE_OPTIONAL) ? int'(LANE_OPTIONAL) : int'(c.lane);
        if (!intake_open) begin
          verdict = ST_NOT_ACCEPTING;
        end else if (lanes_total() >= eff_cap ||
                     (ln != LANE_DIRECT && nondirect >= nd_bound) ||
                     (ln != LANE_DIRECT && nondirect >= int'(nondirect_reg)) ||
                     (ln == LANE_OPTIONAL && lane_fill[LANE_OPTIONAL] >= int'(optional_reg))) begin
          verdict = ST_FULL;
        end else begin
          verdict = ST_ACCEPTED;
          pos = (lane_head[ln] + lane_fill[ln]) % QUEUE_SLOTS;
          lane_store[ln][pos].cancel = c.cancel;
          lane_store[ln][pos].tag    = c.tag;
          lane_fill[ln]++;
        end
        add_expected(make_result(verdict, LANE_DIRECT, '0, 1'b1));
      end
      FUNC_DISPATCH: begin
        workers = (int'(workers_reg) > MAX_WORKERS) ? MAX_WORKERS : int'(workers_reg);
        if (lanes_total() == 0 || busy_tasks >= workers) begin
          // refused dispatch leaves the schedule where it was
          add_expected(make_result(ST_NOTHING_READY, LANE_DIRECT, '0, 1'b1));
        end else begin
          // walk the schedule, skipping empty lanes; one full turn always hits
          pick = -1;
          for (i = 0; i < WRR_SLOTS && pick < 0; i++) begin
            if (lane_fill[slot_lane(weighted_pos)] != 0) pick = slot_lane(weighted_pos);
            weighted_pos = (weighted_pos + 1) % WRR_SLOTS;
          end
          e = lane_store[pick][lane_head[pick]];
          lane_head[pick] = (lane_head[pick] + 1) % QUEUE_SLOTS;
          lane_fill[pick]--;
          busy_tasks++;
          add_expected(make_result(ST_DISPATCHED, 2'(pick), e.tag, 1'b1));
        end
      end
      FUNC_COMPLETE: begin
        if (busy_tasks == 0) begin
          add_expected(make_result(ST_NOTHING_ACTIVE, LANE_DIRECT, '0, 1'b1));
        end else begin
          busy_tasks--;
          add_expected(make_result(ST_COMPLETED, LANE_DIRECT, '0, 1'b1));
        end
      end
      FUNC_START: begin
        if (ever_started) begin
          add_expected(make_result(ST_ALREADY_STARTED, LANE_DIRECT, '0, 1'b1));
        end else begin
          ever_started = 1'b1;
          intake_open  = 1'b1;
          add_expected(make_result(ST_STARTED, LANE_DIRECT, '0, 1'b1));
        end
      end
      FUNC_STOP: begin
        // intake closes and every lane empties before any result is formed
        intake_open = 1'b0;
        for (l = 0; l < LANES; l++) begin
          old_head[l]  = lane_head[l];
          old_fill[l]  = lane_fill[l];
          lane_head[l] = 0;
          lane_fill[l] = 0;
        end
        // one result per flushed entry with a cancel, lane order then fifo
        // order; the newest one is held back so the final one can carry last
        have_held = 1'b0;
        for (l = 0; l < LANES; l++) begin
          for (j = 0; j < old_fill[l]; j++) begin
            e = lane_store[l][(old_head[l] + j) % QUEUE_SLOTS];
            if (e.cancel) begin
              if (have_held) add_expected(held);
              held      = make_result(ST_CANCELLED, 2'(l), e.tag, 1'b0);
              have_held = 1'b1;
            end
          end
        end
        if (have_held) begin
          held.last = 1'b1;
          add_expected(held);
        end else begin
          add_expected(make_result(ST_STOPPED, LANE_DIRECT, '0, 1'b1));
        end
      end
      FUNC_SNAPSHOT: begin
        add_expected(make_result(ST_SNAPSHOT, LANE_DIRECT, '0, 1'b1));
      end
      default: begin
        // spare func codes: no result, no state change
      end
    endcase
  endtask

  // ------------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------------

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_result();
    result_t want;
    result_t got;
    got = {status, lane_out, tag_out, last, queued_total, active_total, accepting_flag};
    if (await_rd == await_wr) begin
      $display("%0t: unexpected result, expected none, got status %0d lane %0d tag %0h",
               $time, status, lane_out, tag_out);
      mismatch_count++;
    end else begin
      want = awaited_results[await_rd];
      await_rd++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("lane_out", 32'(want.lane), 32'(got.lane));
      compare_field("tag_out", 32'(want.tag), 32'(got.tag));
      compare_field("last", 32'(want.last), 32'(got.last));
      compare_field("queued_total", 32'(want.queued), 32'(got.queued));
      compare_field("active_total", 32'(want.active), 32'(got.active));
      compare_field("accepting_flag", 32'(want.accepting), 32'(got.accepting));
    end
  endtask

  // monitor: handshakes are sampled at the rising edge only
  always @(posedge clk) begin
    if (rst) begin
      cmd_taken    <= 1'b0;
      result_taken <= 1'b0;
    end else begin
      cmd_taken    <= in_valid && in_ready;
      result_taken <= out_valid && out_ready;
      // results first: a result taken now always belongs to an older item
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) begin
        predict_queue_step({func, lane, task_tag, has_cancel});
        commands_taken++;
      end
    end
  end

  // ------------------------------------------------------------------------
  // driver and receiver, both on the falling edge
  // ------------------------------------------------------------------------

  // command driver: holds an item until taken, then idles for a drawn gap
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_hold = 0;
    end else if (!in_valid || cmd_taken) begin
      if (send_hold > 0) begin
        in_valid <= 1'b0;
        send_hold--;
      end else if (backlog_rd != backlog_wr) begin
        next_cmd = command_backlog[backlog_rd];
        backlog_rd++;
        func       <= next_cmd.func;
        lane       <= next_cmd.lane;
        task_tag   <= next_cmd.tag;
        has_cancel <= next_cmd.cancel;
        in_valid   <= 1'b1;
        send_hold  = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: after each taken item, stalls for a drawn number of cycles
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (result_taken) recv_hold = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (recv_hold > 0) begin
        out_ready <= 1'b0;
        recv_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------

  task automatic send(logic [2:0] f, logic [1:0] ln, logic [TAG_BITS-1:0] tg, logic cx);
    command_t c;
    c.func   = f;
    c.lane   = ln;
    c.tag    = tg;
    c.cancel = cx;
    command_backlog[backlog_wr] = c;
    backlog_wr++;
    commands_issued++;
  endtask

  // wait until every item is taken and every result has arrived
  task automatic drain();
    while (backlog_rd != backlog_wr || commands_taken != commands_issued ||
           await_rd != await_wr) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write at a falling edge, only while the block is idle
  task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_CAPACITY:        capacity_reg  = value;
      CFG_DIRECT_RESERVE:  reserve_reg   = value;
      CFG_NONDIRECT_LIMIT: nondirect_reg = value;
      CFG_OPTIONAL_LIMIT:  optional_reg  = value;
      CFG_WORKER_LIMIT:    workers_reg   = value[WORKER_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one phase: settle, program all registers, then a random command mix;
  // percentages pick submit / dispatch / complete, the rest goes to the
  // other commands (stop only where allowed, since it closes intake for good)
  task automatic run_phase(int cap, int reserve, int nd, int opt, int wk, int items,
                           int p_sub, int p_disp, int p_comp, bit allow_stop, bit steady);
    int                  counted, roll;
    logic [2:0]          f;
    logic [1:0]          ln;
    logic [TAG_BITS-1:0] tg;
    logic                cx;
    drain();
    write_register(CFG_CAPACITY, CFG_BITS'(cap));
    write_register(CFG_DIRECT_RESERVE, CFG_BITS'(reserve));
    write_register(CFG_NONDIRECT_LIMIT, CFG_BITS'(nd));
    write_register(CFG_OPTIONAL_LIMIT, CFG_BITS'(opt));
    write_register(CFG_WORKER_LIMIT, CFG_BITS'(wk));
    no_gaps = steady;
    counted = 0;
    while (counted < items) begin
      roll = $urandom_range(0, 99);
      ln   = 2'($urandom_range(0, 3));
      tg   = TAG_BITS'($urandom_range(0, 16'hFFFF));
      cx   = 1'($urandom_range(0, 1));
      if (roll < p_sub) begin
        f = FUNC_SUBMIT;
      end else if (roll < p_sub + p_disp) begin
        f = FUNC_DISPATCH;
      end else if (roll < p_sub + p_disp + p_comp) begin
        f = FUNC_COMPLETE;
      end else begin
        case ($urandom_range(0, allow_stop ? 4 : 3))
          0:       f = FUNC_START;
          1:       f = FUNC_SNAPSHOT;
          2:       f = FUNC_SPARE_A;
          3:       f = FUNC_SPARE_B;
          default: f = FUNC_STOP;
        endcase
      end
      send(f, ln, tg, cx);
      // ignored codes do not count toward the phase length
      if (f != FUNC_SPARE_A && f != FUNC_SPARE_B) counted++;
    end
  endtask

  initial begin
    clear_queue_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: everything before start is refused or empty
    send(FUNC_SUBMIT, LANE_DIRECT, 16'hFFFF, 1'b1);
    send(FUNC_DISPATCH, LANE_DIRECT, '0, 1'b0);
    send(FUNC_COMPLETE, LANE_DIRECT, '0, 1'b0);
    send(FUNC_SNAPSHOT, LANE_SPARE, 16'hFFFF, 1'b1);
    send(FUNC_SPARE_A, LANE_EXPLICIT, 16'h1234, 1'b0);
    send(FUNC_SPARE_B, LANE_OPTIONAL, 16'h4321, 1'b1);
    // stop before start: nothing to flush, start is still allowed afterwards
    send(FUNC_STOP, LANE_DIRECT, '0, 1'b0);
    send(FUNC_START, LANE_DIRECT, '0, 1'b0);
    send(FUNC_START, LANE_DIRECT, '0, 1'b0);
    // one submit per lane code, tag extremes, lane three aliasing optional
    send(FUNC_SUBMIT, LANE_DIRECT, 16'h0000, 1'b0);
    send(FUNC_SUBMIT, LANE_EXPLICIT, 16'hFFFF, 1'b1);
    send(FUNC_SUBMIT, LANE_OPTIONAL, 16'h5A5A, 1'b0);
    send(FUNC_SUBMIT, LANE_SPARE, 16'hA5A5, 1'b1);
    // one worker after reset: second dispatch is refused while the first runs
    send(FUNC_DISPATCH, LANE_DIRECT, '0, 1'b0);
    send(FUNC_DISPATCH, LANE_DIRECT, '0, 1'b0);
    send(FUNC_COMPLETE, LANE_DIRECT, '0, 1'b0);
    send(FUNC_COMPLETE, LANE_DIRECT, '0, 1'b0);
    send(FUNC_SNAPSHOT, LANE_DIRECT, '0, 1'b0);

    // random phases, each behind a full drain
    // fill-heavy with the reset admission limits and four workers, so every limit gets hit
    run_phase(64, 16, 48, 32, 4, 80, 75, 12, 10, 1'b0, 1'b0);
    // capacity above the store size, no reserve, most workers, no idling
    run_phase(127, 0, 64, 64, 16, 60, 35, 35, 25, 1'b0, 1'b1);
    // zero capacity and zero workers: every submit full, every dispatch refused
    run_phase(0, 0, 0, 0, 0, 30, 40, 30, 20, 1'b0, 1'b0);
    // reserve equal to capacity is ignored; worker count above the maximum
    run_phase(10, 10, 64, 64, 31, 50, 50, 25, 20, 1'b0, 1'b0);
    // reserve above capacity, tight non-direct and optional limits
    run_phase(20, 127, 5, 2, 2, 50, 50, 25, 20, 1'b0, 1'b1);
    // smallest capacity, no room at all for non-direct lanes
    run_phase(1, 0, 0, 0, 1, 40, 50, 25, 20, 1'b0, 1'b0);
    run_phase(40, 8, 20, 10, 3, 80, 45, 28, 22, 1'b0, 1'b0);
    // fill every lane as far as it goes, then flush it with one stop
    run_phase(64, 0, 64, 64, 16, 70, 92, 3, 3, 1'b0, 1'b0);
    send(FUNC_STOP, LANE_DIRECT, '0, 1'b0);
    // after the flush intake stays closed: refusals, restarts and more stops
    run_phase(64, 16, 48, 32, 5, 40, 40, 20, 20, 1'b1, 1'b0);

    drain();
    if (mismatch_count == 0) begin
      $display("three_lane_weighted_admission_queue_test: done, clean");
    end else begin
      $display("three_lane_weighted_admission_queue_test: done, errors");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("three_lane_weighted_admission_queue_test: done, errors");
    $finish;
  end

endmodule
